// ===== hw/rtl/sliding_window_conv3x3_unit_defines.svh =====
// Assertion macros shared by the checker files of the 3x3 convolution unit.
// Depends on nothing; each macro expects clk_i and rst_ni in the using scope.
`ifndef SLIDING_WINDOW_CONV3X3_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_CONV3X3_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside of reset.
`define SWC_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside of reset.
`define SWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/swc_pkg.sv =====
// Shared constants and types of the 3x3 sliding-window convolution unit.
// Depends on nothing; the RTL modules use it by scoped names.
package swc_pkg;

  // Image geometry and window shape.
  localparam int LINE_WIDTH  = 512;
  localparam int KERNEL_SIZE = 3;
  localparam int STORE_LEN   = 2 * LINE_WIDTH + KERNEL_SIZE;
  localparam int WIN_N       = KERNEL_SIZE * KERNEL_SIZE;

  // Datapath widths.
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 8;
  localparam int PROD_W  = 16;  // unsigned pixel times signed byte
  localparam int ROW_W   = 18;  // sum of three products
  localparam int SUM_W   = 20;  // sum of nine products
  localparam int MAG_W   = 19;  // magnitude of the sum
  localparam int DIV_W   = 8;   // magnitude of the divisor, up to 128
  localparam int QUO_W   = 8;   // quotient bits before saturation
  localparam int DSH_W   = DIV_W + QUO_W - 1;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int ROWREG_W = KERNEL_SIZE * COEF_W;

  // Stream and configuration port widths.
  localparam int TDATA_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 8'd3;

  // Register reset values.
  localparam logic [ROWREG_W-1:0] KERNEL_TOP_RST = 24'h000000;
  localparam logic [ROWREG_W-1:0] KERNEL_MID_RST = 24'h000100;
  localparam logic [ROWREG_W-1:0] KERNEL_BOT_RST = 24'h000000;
  localparam logic [COEF_W-1:0]   SCALE_RST      = 8'h01;

  // Clamp limit of the output pixel.
  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] window_t;  // entry r*KERNEL_SIZE+c

  // Request to the divider: start pulse with operand magnitudes.
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // Answer of the divider: done pulse with the saturated quotient.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/sliding_window_conv3x3_unit.sv =====
// Streaming 3x3 convolution over a pixel line store, with divide and clamp.
// Depends on swc_pkg, swc_chain (swc_cell) and swc_divider.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------
//   cfg      | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//   s_axis   | in        | tvalid/tready        | tdata pixel+sideband, tlast, tuser
//   m_axis   | out       | tvalid/tready        | tdata pixel+sideband, tlast, tuser
//
// One item at a time: states MUL, ROW, SUM, START, WAIT (the divider checks for
// saturation, then forms one quotient bit per cycle) and OUT, which loads the
// result once the output is free. The input is ready again in the cycle after a
// result is loaded. The output register lets the next item in while a result
// waits. Reset clears the line store cells and the sequencer registers at once,
// with no clearing pass. Configuration is always ready.
module sliding_window_conv3x3_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [swc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [swc_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: [7:0] pixel_in, [8] keep_in, [9] strobe_in, [10] dest_in,
  //        [11] ident_in, [15:12] zero
  input  logic [swc_pkg::TDATA_W-1:0]     s_axis_tdata,
  input  logic                            s_axis_tlast,
  // tuser: [0] user_in
  input  logic                            s_axis_tuser,
  // Output stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: [7:0] pixel_out, [8] keep_out, [9] strobe_out, [10] dest_out,
  //        [11] ident_out, [15:12] zero
  output logic [swc_pkg::TDATA_W-1:0]     m_axis_tdata,
  output logic                            m_axis_tlast,
  // tuser: [0] user_out
  output logic                            m_axis_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ROW,
    S_SUM,
    S_START,
    S_WAIT,
    S_OUT
  } state_e;

  // Sideband bits that ride along with an item.
  typedef struct packed {
    logic keep;
    logic strobe;
    logic last;
    logic dest;
    logic ident;
    logic user;
  } sideband_t;

  state_e state_q, state_d;

  logic [swc_pkg::ROWREG_W-1:0] kernel_q [swc_pkg::KERNEL_SIZE];
  logic signed [swc_pkg::COEF_W-1:0] scale_q;

  logic                 s_accept;
  swc_pkg::window_t     window;
  swc_pkg::div_req_t    div_req;
  swc_pkg::div_rsp_t    div_rsp;

  logic signed [swc_pkg::COEF_W-1:0] coef [swc_pkg::WIN_N];
  logic signed [swc_pkg::PROD_W:0]   prod_full [swc_pkg::WIN_N];
  logic signed [swc_pkg::PROD_W-1:0] prod_d [swc_pkg::WIN_N];
  logic signed [swc_pkg::PROD_W-1:0] prod_q [swc_pkg::WIN_N];
  logic signed [swc_pkg::ROW_W-1:0]  row_d [swc_pkg::KERNEL_SIZE];
  logic signed [swc_pkg::ROW_W-1:0]  row_q [swc_pkg::KERNEL_SIZE];
  logic signed [swc_pkg::SUM_W-1:0]  total;
  logic signed [swc_pkg::DIV_W:0]    scale_neg;

  logic [swc_pkg::MAG_W-1:0] mag_q, mag_d;
  logic [swc_pkg::DIV_W-1:0] dmag_q, dmag_d;
  logic                      neg_q, neg_d;
  swc_pkg::pix_t             res_q, res_d;
  sideband_t                 sb_q, sb_d;
  logic                      m_valid_q, m_valid_d;
  swc_pkg::pix_t             m_pix_q, m_pix_d;
  sideband_t                 m_sb_q, m_sb_d;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q[0] <= swc_pkg::KERNEL_TOP_RST;
      kernel_q[1] <= swc_pkg::KERNEL_MID_RST;
      kernel_q[2] <= swc_pkg::KERNEL_BOT_RST;
      scale_q     <= swc_pkg::SCALE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        swc_pkg::CFG_KERNEL_TOP: kernel_q[0] <= cfg_data_i;
        swc_pkg::CFG_KERNEL_MID: kernel_q[1] <= cfg_data_i;
        swc_pkg::CFG_KERNEL_BOT: kernel_q[2] <= cfg_data_i;
        swc_pkg::CFG_SCALE:      scale_q <= cfg_data_i[swc_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixel line store with the window taps.
  swc_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (s_accept),
    .pix_i      (s_axis_tdata[swc_pkg::PIX_W-1:0]),
    .window_o   (window)
  );

  // Coefficients: column c of each row register sits in byte c.
  for (genvar r = 0; r < swc_pkg::KERNEL_SIZE; r++) begin : g_coef_row
    for (genvar c = 0; c < swc_pkg::KERNEL_SIZE; c++) begin : g_coef_col
      assign coef[r*swc_pkg::KERNEL_SIZE+c] =
        $signed(kernel_q[r][c*swc_pkg::COEF_W +: swc_pkg::COEF_W]);
    end
  end

  // Nine products, one per window position.
  always_comb begin
    for (int i = 0; i < swc_pkg::WIN_N; i++) begin
      prod_full[i] = $signed({1'b0, window[i]}) * coef[i];
      prod_d[i]    = prod_full[i][swc_pkg::PROD_W-1:0];
    end
  end

  // Row sums of three products each.
  always_comb begin
    for (int r = 0; r < swc_pkg::KERNEL_SIZE; r++) begin
      row_d[r] = (swc_pkg::ROW_W)'(prod_q[r*swc_pkg::KERNEL_SIZE])
               + (swc_pkg::ROW_W)'(prod_q[r*swc_pkg::KERNEL_SIZE+1])
               + (swc_pkg::ROW_W)'(prod_q[r*swc_pkg::KERNEL_SIZE+2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_ROW) begin
      row_q <= row_d;
    end
  end

  // Full sum, and the sign-magnitude form that the divider takes.
  assign total = (swc_pkg::SUM_W)'(row_q[0]) + (swc_pkg::SUM_W)'(row_q[1])
               + (swc_pkg::SUM_W)'(row_q[2]);
  assign scale_neg = -$signed({scale_q[swc_pkg::COEF_W-1], scale_q});

  // Divider hookup.
  assign div_req.start    = (state_q == S_START);
  assign div_req.dividend = mag_q;
  assign div_req.divisor  = dmag_q;

  swc_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer and output register.
  always_comb begin
    state_d   = state_q;
    mag_d     = mag_q;
    dmag_d    = dmag_q;
    neg_d     = neg_q;
    res_d     = res_q;
    sb_d      = sb_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_pix_d   = m_pix_q;
    m_sb_d    = m_sb_q;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          sb_d.keep   = s_axis_tdata[8];
          sb_d.strobe = s_axis_tdata[9];
          sb_d.dest   = s_axis_tdata[10];
          sb_d.ident  = s_axis_tdata[11];
          sb_d.last   = s_axis_tlast;
          sb_d.user   = s_axis_tuser;
          state_d     = S_MUL;
        end
      end
      S_MUL: state_d = S_ROW;
      S_ROW: state_d = S_SUM;
      S_SUM: begin
        // A quotient whose operands differ in sign is never above zero.
        mag_d = total[swc_pkg::SUM_W-1] ? (swc_pkg::MAG_W)'(-total)
                                        : (swc_pkg::MAG_W)'(total);
        neg_d = total[swc_pkg::SUM_W-1] ^ scale_q[swc_pkg::COEF_W-1];
        if (scale_q == '0) begin
          dmag_d = (swc_pkg::DIV_W)'(1);
        end else if (scale_q[swc_pkg::COEF_W-1]) begin
          dmag_d = scale_neg[swc_pkg::DIV_W-1:0];
        end else begin
          dmag_d = (swc_pkg::DIV_W)'(scale_q);
        end
        state_d = S_START;
      end
      S_START: state_d = S_WAIT;
      S_WAIT: begin
        if (div_rsp.done) begin
          res_d   = neg_q ? '0 : div_rsp.quotient;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_pix_d   = res_q;
          m_sb_d    = sb_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      mag_q     <= '0;
      dmag_q    <= '0;
      neg_q     <= 1'b0;
      res_q     <= '0;
      sb_q      <= '0;
      m_pix_q   <= '0;
      m_sb_q    <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      mag_q     <= mag_d;
      dmag_q    <= dmag_d;
      neg_q     <= neg_d;
      res_q     <= res_d;
      sb_q      <= sb_d;
      m_pix_q   <= m_pix_d;
      m_sb_q    <= m_sb_d;
    end
  end

  // Output packing.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, m_sb_q.ident, m_sb_q.dest, m_sb_q.strobe,
                          m_sb_q.keep, m_pix_q};
  assign m_axis_tlast  = m_sb_q.last;
  assign m_axis_tuser  = m_sb_q.user;

endmodule

// ===== hw/rtl/swc_cell.sv =====
// One cell of the pixel line store: holds one pixel, passes it on each shift.
// Depends on swc_pkg.
module swc_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_en_i,
  input  swc_pkg::pix_t pix_i,
  output swc_pkg::pix_t pix_o
);

  swc_pkg::pix_t pix_q;

  // Take the neighbor's pixel on every accepted item; reset clears the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
    end else if (shift_en_i) begin
      pix_q <= pix_i;
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== hw/rtl/swc_chain.sv =====
// Line store built as a chain of pixel cells, with the 3x3 window taps.
// Depends on swc_pkg and swc_cell.
module swc_chain (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_en_i,
  input  swc_pkg::pix_t    pix_i,
  output swc_pkg::window_t window_o
);

  // Cell k holds store element k; the newest pixel enters the last cell.
  swc_pkg::pix_t link [swc_pkg::STORE_LEN];

  for (genvar k = 0; k < swc_pkg::STORE_LEN; k++) begin : g_cell
    swc_pkg::pix_t cell_in;

    if (k == swc_pkg::STORE_LEN - 1) begin : g_head
      assign cell_in = pix_i;
    end else begin : g_body
      assign cell_in = link[k+1];
    end

    swc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en_i),
      .pix_i      (cell_in),
      .pix_o      (link[k])
    );
  end

  // Window row r lies r lines newer than the oldest row.
  for (genvar r = 0; r < swc_pkg::KERNEL_SIZE; r++) begin : g_row
    for (genvar c = 0; c < swc_pkg::KERNEL_SIZE; c++) begin : g_col
      assign window_o[r*swc_pkg::KERNEL_SIZE+c] = link[r*swc_pkg::LINE_WIDTH+c];
    end
  end

endmodule

// ===== hw/rtl/swc_divider.sv =====
// Restoring divider, one quotient bit per cycle, saturating above 255.
// Depends on swc_pkg.
module swc_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swc_pkg::div_req_t req_i,
  output swc_pkg::div_rsp_t rsp_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [swc_pkg::STEP_W-1:0]  step_q;
  logic                        sat_q;
  logic [swc_pkg::MAG_W-1:0]   rem_q;
  logic [swc_pkg::DSH_W-1:0]   dsh_q;
  logic [swc_pkg::QUO_W-1:0]   quo_q;
  logic [swc_pkg::DSH_W-1:0]   dsh_init;
  logic [swc_pkg::MAG_W-1:0]   sat_limit;
  logic                        ge;

  // Divisor aligned to the top quotient bit, and the first value that saturates.
  assign dsh_init  = {req_i.divisor, {(swc_pkg::QUO_W-1){1'b0}}};
  assign sat_limit = (swc_pkg::MAG_W)'({req_i.divisor, {swc_pkg::QUO_W{1'b0}}});
  assign ge        = rem_q >= (swc_pkg::MAG_W)'(dsh_q);

  // Control: count the quotient bits and pulse done after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == (swc_pkg::STEP_W)'(swc_pkg::QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: one compare and subtract per step.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      dsh_q <= dsh_init;
      quo_q <= '0;
      sat_q <= req_i.dividend >= sat_limit;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - (swc_pkg::MAG_W)'(dsh_q);
      end
      quo_q <= {quo_q[swc_pkg::QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = sat_q ? swc_pkg::PIX_MAX : quo_q;

endmodule

// ===== hw/rtl/swc_checker.sv =====
// Port-level checks of the 3x3 convolution unit, bound to the top level.
// Depends on swc_pkg and sliding_window_conv3x3_unit_defines.svh.
`include "sliding_window_conv3x3_unit_defines.svh"

module swc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [swc_pkg::TDATA_W-1:0]     m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            m_axis_tuser
);

  logic                          s_accept;
  logic                          m_stall;
  logic [swc_pkg::TDATA_W+1:0]   m_beat;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_stall  = m_axis_tvalid && !m_axis_tready;
  assign m_beat   = {m_axis_tuser, m_axis_tlast, m_axis_tdata};

  // Configuration writes are never held off.
  `SWC_ASSERT(a_cfg_always_ready, cfg_valid_i, cfg_ready_o, "config write stalled")

  // The block works on one item at a time, so it is busy right after an accept.
  `SWC_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_axis_tready, "input taken twice in a row")

  // A stalled result stays put.
  `SWC_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid && $stable(m_beat), "stalled result changed")

  // Padding bits of the output data are zero.
  `SWC_ASSERT(a_out_pad_zero, m_axis_tvalid, m_axis_tdata[15:12] == 4'b0000, "padding not zero")

endmodule

bind sliding_window_conv3x3_unit swc_checker u_swc_checker (.*);
